>>> sv/tcpopt_pkg.sv
// Package for the TCP option parser: parse phase encoding, option kind codes
// and configuration register indexes. No dependencies.
package tcpopt_pkg;

  // Option kind codes with a fixed meaning
  localparam logic [7:0] KIND_END    = 8'd0;
  localparam logic [7:0] KIND_NOP    = 8'd1;
  localparam logic [7:0] KIND_MSS    = 8'd2;
  localparam logic [7:0] KIND_WSCALE = 8'd3;
  localparam logic [7:0] KIND_SACKP  = 8'd4;
  localparam logic [7:0] KIND_TS     = 8'd8;

  // Configuration register indexes (paddr[2])
  localparam logic REG_MSS_OVERHEAD    = 1'b0;
  localparam logic REG_INT_OPTION_KIND = 1'b1;

  // Reset values of the configuration registers
  localparam logic [5:0] MSS_OVERHEAD_RST    = 6'd12;
  localparam logic [7:0] INT_OPTION_KIND_RST = 8'd254;

  // Parse phase: body phases count the first four body bytes
  typedef enum logic [2:0] {
    PH_KIND      = 3'd0,
    PH_LEN       = 3'd1,
    PH_BODY0     = 3'd2,
    PH_BODY1     = 3'd3,
    PH_BODY2     = 3'd4,
    PH_BODY3     = 3'd5,
    PH_BODY_REST = 3'd6
  } phase_t;

endpackage

>>> sv/tcp_option_parser.sv
// TCP option parser top level: input register, byte parser and result register.
// Depends on tcpopt_pkg.
//
// Takes one TCP option byte per cycle while in_stall is low, with the segment's
// option length and the current time, and keeps the peer's MSS, effective MSS
// (MSS less mss_overhead, floored at zero), window scale, SACK-permitted,
// timestamp value with its arrival time, and a 16-bit value from the option kind
// set in int_option_kind when that is not a fixed kind. Captured values persist
// across segments; a summary item is given on each byte flagged last_byte. Each
// byte passes an input register and the combinational parse logic and, on the
// last byte, a result register, which holds the summary until it is taken.
// Output stalls back up into the input only when a summary is pending.
// Registers: mss_overhead at 0x0, int_option_kind at 0x4.
module tcp_option_parser #(
  parameter int MAX_OPTION_BYTES = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  // option byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_opt_byte,
  input  logic        in_last_byte,
  input  logic [5:0]  in_block_length,
  input  logic [31:0] in_arrival_time,
  // summary channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_peer_mss,
  output logic [15:0] out_effective_mss,
  output logic [7:0]  out_peer_window_scale,
  output logic        out_sack_permitted,
  output logic        out_timestamp_seen,
  output logic [31:0] out_recent_timestamp,
  output logic [31:0] out_timestamp_update_time,
  output logic [15:0] out_telemetry_value,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tcpopt_pkg::*;

  localparam logic [5:0] MaxLen = 6'(MAX_OPTION_BYTES);

  // configuration registers
  logic [5:0] mss_overhead_r;
  logic [7:0] int_option_kind_r;

  // input register
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic [5:0]  s1_len_r;
  logic [31:0] s1_time_r;

  // per-block parse state
  logic [5:0]  pos_r, pos_nxt;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [7:0]  btc_r, btc_nxt;
  logic [23:0] asm_r, asm_nxt;
  logic        stopped_r, stopped_nxt;

  // captured values
  logic [15:0] mss_r, mss_nxt;
  logic [15:0] eff_r, eff_nxt;
  logic [7:0]  wscale_r, wscale_nxt;
  logic        sack_r, sack_nxt;
  logic        ts_flag_r, ts_flag_nxt;
  logic [31:0] ts_value_r, ts_value_nxt;
  logic [31:0] ts_time_r, ts_time_nxt;
  logic [15:0] int_r, int_nxt;

  logic out_valid_r;
  logic s1_adv;
  logic in_acc;
  logic cfg_wr;

  // Configuration writes and reads
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mss_overhead_r    <= MSS_OVERHEAD_RST;
      int_option_kind_r <= INT_OPTION_KIND_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_MSS_OVERHEAD:    mss_overhead_r    <= pwdata[5:0];
        REG_INT_OPTION_KIND: int_option_kind_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MSS_OVERHEAD:    prdata = {26'd0, mss_overhead_r};
      REG_INT_OPTION_KIND: prdata = {24'd0, int_option_kind_r};
      default:             prdata = '0;
    endcase
  end

  // Handshake: a non-last item always advances; a last item needs the result slot
  assign s1_adv   = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // Capture the input item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_opt_byte;
      s1_last_r <= in_last_byte;
      s1_len_r  <= (in_block_length > MaxLen) ? MaxLen : in_block_length;
      s1_time_r <= in_arrival_time;
    end
  end

  // Parse one byte
  logic        active;
  logic        fixed_kind;
  logic [8:0]  opt_end;
  logic [15:0] new_mss;
  logic [7:0]  btc_dec;

  always_comb begin
    pos_nxt      = pos_r;
    phase_nxt    = phase_r;
    kind_nxt     = kind_r;
    btc_nxt      = btc_r;
    asm_nxt      = asm_r;
    stopped_nxt  = stopped_r;
    mss_nxt      = mss_r;
    eff_nxt      = eff_r;
    wscale_nxt   = wscale_r;
    sack_nxt     = sack_r;
    ts_flag_nxt  = ts_flag_r;
    ts_value_nxt = ts_value_r;
    ts_time_nxt  = ts_time_r;
    int_nxt      = int_r;

    active     = !stopped_r && (pos_r < s1_len_r);
    fixed_kind = (kind_r == KIND_MSS) || (kind_r == KIND_WSCALE) ||
                 (kind_r == KIND_SACKP) || (kind_r == KIND_TS);
    // option end position (index of its last byte) + 2, compared against usable length + 1
    opt_end    = {3'd0, pos_r} + {1'b0, s1_byte_r};
    new_mss    = {asm_r[7:0], s1_byte_r};
    btc_dec    = btc_r - 8'd1;

    if (active) begin
      case (phase_r)
        PH_KIND: begin
          if (s1_byte_r == KIND_END) begin
            stopped_nxt = 1'b1;
          end else if (s1_byte_r != KIND_NOP) begin
            kind_nxt  = s1_byte_r;
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          if (s1_byte_r < 8'd2 || opt_end > {3'd0, s1_len_r} + 9'd1) begin
            stopped_nxt = 1'b1;
          end else begin
            btc_nxt = s1_byte_r - 8'd2;
            asm_nxt = '0;
            if (kind_r == KIND_SACKP) sack_nxt = 1'b1;
            phase_nxt = (s1_byte_r == 8'd2) ? PH_KIND : PH_BODY0;
          end
        end
        default: begin
          // first four body bytes feed the assembly word and value captures
          if (phase_r != PH_BODY_REST) begin
            asm_nxt = {asm_r[15:0], s1_byte_r};
            if (kind_r == KIND_MSS && phase_r == PH_BODY1) begin
              mss_nxt = new_mss;
              eff_nxt = (new_mss > {10'd0, mss_overhead_r}) ?
                        new_mss - {10'd0, mss_overhead_r} : 16'd0;
            end else if (kind_r == KIND_WSCALE && phase_r == PH_BODY0) begin
              wscale_nxt = s1_byte_r;
            end else if (kind_r == KIND_TS && phase_r == PH_BODY3) begin
              ts_flag_nxt  = 1'b1;
              ts_value_nxt = {asm_r, s1_byte_r};
              ts_time_nxt  = s1_time_r;
            end else if (!fixed_kind && kind_r == int_option_kind_r &&
                         phase_r == PH_BODY1) begin
              int_nxt = new_mss;
            end
          end
          btc_nxt = btc_dec;
          if (btc_dec == 8'd0) begin
            phase_nxt = PH_KIND;
          end else if (phase_r != PH_BODY_REST) begin
            phase_nxt = phase_t'(phase_r + 3'd1);
          end
        end
      endcase
    end

    // advance position, saturating
    if (pos_r != 6'd63) pos_nxt = pos_r + 6'd1;

    // drop per-block state after the last byte
    if (s1_last_r) begin
      pos_nxt     = '0;
      phase_nxt   = PH_KIND;
      kind_nxt    = '0;
      btc_nxt     = '0;
      asm_nxt     = '0;
      stopped_nxt = 1'b0;
    end
  end

  // Update parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      phase_r    <= PH_KIND;
      kind_r     <= '0;
      btc_r      <= '0;
      asm_r      <= '0;
      stopped_r  <= 1'b0;
      mss_r      <= '0;
      eff_r      <= '0;
      wscale_r   <= '0;
      sack_r     <= 1'b0;
      ts_flag_r  <= 1'b0;
      ts_value_r <= '0;
      ts_time_r  <= '0;
      int_r      <= '0;
    end else if (s1_adv) begin
      pos_r      <= pos_nxt;
      phase_r    <= phase_nxt;
      kind_r     <= kind_nxt;
      btc_r      <= btc_nxt;
      asm_r      <= asm_nxt;
      stopped_r  <= stopped_nxt;
      mss_r      <= mss_nxt;
      eff_r      <= eff_nxt;
      wscale_r   <= wscale_nxt;
      sack_r     <= sack_nxt;
      ts_flag_r  <= ts_flag_nxt;
      ts_value_r <= ts_value_nxt;
      ts_time_r  <= ts_time_nxt;
      int_r      <= int_nxt;
    end
  end

  // Result register: load a summary on the last byte, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_peer_mss              <= mss_nxt;
      out_effective_mss         <= eff_nxt;
      out_peer_window_scale     <= wscale_nxt;
      out_sack_permitted        <= sack_nxt;
      out_timestamp_seen        <= ts_flag_nxt;
      out_recent_timestamp      <= ts_value_nxt;
      out_timestamp_update_time <= ts_time_nxt;
      out_telemetry_value       <= int_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // Block state is cleared after each last byte
  a_block_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> (pos_r == 6'd0 && !stopped_r && phase_r == PH_KIND))
    else $error("parse state not cleared after last byte");

  // A body phase always has bytes left to consume
  a_body_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_KIND && phase_r != PH_LEN) |-> (btc_r != 8'd0))
    else $error("body phase with nothing to consume");

  // Effective MSS never exceeds the peer MSS
  a_eff_mss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_effective_mss <= out_peer_mss))
    else $error("effective MSS above peer MSS");

  // A non-last byte never creates a summary
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !(s1_adv && s1_last_r)) |=> !out_valid_r)
    else $error("summary appeared without a last byte");

endmodule

>>> tb/tcp_option_parser_tb.sv
// Self-checking testbench for tcp_option_parser: random option blocks, predicted
// summaries, field-by-field compare. Depends on tcpopt_pkg and the parser RTL.
`timescale 1ns / 100ps

module tcp_option_parser_tb;
  import tcpopt_pkg::*;

  localparam int MAX_OPT      = 40;
  localparam int DRAIN_CYCLES = 8;
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 300;

  typedef struct {
    logic [7:0]  opt_byte;
    logic        last_byte;
    logic [5:0]  block_length;
    logic [31:0] arrival_time;
  } opt_item_t;

  typedef struct {
    logic [15:0] peer_mss;
    logic [15:0] effective_mss;
    logic [7:0]  peer_window_scale;
    logic        sack_permitted;
    logic        timestamp_seen;
    logic [31:0] recent_timestamp;
    logic [31:0] timestamp_update_time;
    logic [15:0] telemetry_value;
  } summary_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_opt_byte = '0;
  logic        in_last_byte = 1'b0;
  logic [5:0]  in_block_length = '0;
  logic [31:0] in_arrival_time = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_peer_mss;
  logic [15:0] out_effective_mss;
  logic [7:0]  out_peer_window_scale;
  logic        out_sack_permitted;
  logic        out_timestamp_seen;
  logic [31:0] out_recent_timestamp;
  logic [31:0] out_timestamp_update_time;
  logic [15:0] out_telemetry_value;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  opt_item_t pending_bytes[$];
  summary_t  expected_summaries[$];
  opt_item_t next_item;
  int        taken_count = 0;
  int        offered_count = 0;
  int        sender_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_requests = 0;
  int        hold_served = 0;
  int        hold_cycles = 0;
  int        queued_count = 0;
  int        error_count = 0;
  int        cycle_count = 0;

  // Predictor copy of the configuration
  logic [5:0] cfg_overhead = MSS_OVERHEAD_RST;
  logic [7:0] cfg_int_kind = INT_OPTION_KIND_RST;

  // Predictor copy of the parse state and captured values
  logic [5:0]  pos_count = '0;
  phase_t      parse_ph = PH_KIND;
  logic [7:0]  opt_kind = '0;
  logic [7:0]  body_left = '0;
  logic [31:0] body_word = '0;
  logic        halted = 1'b0;
  logic [15:0] mss_q = '0;
  logic [15:0] eff_mss_q = '0;
  logic [7:0]  wscale_q = '0;
  logic        sackp_q = 1'b0;
  logic        ts_seen_q = 1'b0;
  logic [31:0] ts_val_q = '0;
  logic [31:0] ts_at_q = '0;
  logic [15:0] telem_q = '0;

  tcp_option_parser #(.MAX_OPTION_BYTES(MAX_OPT)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opt_byte(in_opt_byte), .in_last_byte(in_last_byte),
    .in_block_length(in_block_length), .in_arrival_time(in_arrival_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_peer_mss(out_peer_mss), .out_effective_mss(out_effective_mss),
    .out_peer_window_scale(out_peer_window_scale),
    .out_sack_permitted(out_sack_permitted), .out_timestamp_seen(out_timestamp_seen),
    .out_recent_timestamp(out_recent_timestamp),
    .out_timestamp_update_time(out_timestamp_update_time),
    .out_telemetry_value(out_telemetry_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Advance the parser state by one accepted option byte; queue a summary on last
  task automatic advance_parser(input opt_item_t it);
    int lim;
    int posn;
    int idx;
    logic fixed_kind;
    summary_t s;
    lim = (it.block_length > MAX_OPT) ? MAX_OPT : int'(it.block_length);
    posn = int'(pos_count);
    if (!halted && posn < lim) begin
      case (parse_ph)
        PH_KIND: begin
          if (it.opt_byte == KIND_END) begin
            halted = 1'b1;
          end else if (it.opt_byte != KIND_NOP) begin
            opt_kind = it.opt_byte;
            parse_ph = PH_LEN;
          end
        end
        PH_LEN: begin
          // short length or a body running past the block ends parsing
          if (it.opt_byte < 8'd2 || posn + 1 + int'(it.opt_byte) - 2 > lim) begin
            halted = 1'b1;
          end else begin
            body_left = it.opt_byte - 8'd2;
            body_word = '0;
            if (opt_kind == KIND_SACKP) sackp_q = 1'b1;
            parse_ph = (body_left == 8'd0) ? PH_KIND : PH_BODY0;
          end
        end
        default: begin
          idx = int'(parse_ph) - int'(PH_BODY0);
          if (idx < 4) begin
            fixed_kind = (opt_kind == KIND_MSS) || (opt_kind == KIND_WSCALE) ||
                         (opt_kind == KIND_SACKP) || (opt_kind == KIND_TS);
            body_word = {body_word[23:0], it.opt_byte};
            if (opt_kind == KIND_MSS && idx == 1) begin
              mss_q = body_word[15:0];
              eff_mss_q = (mss_q > cfg_overhead) ? mss_q - cfg_overhead : 16'd0;
            end else if (opt_kind == KIND_WSCALE && idx == 0) begin
              wscale_q = it.opt_byte;
            end else if (opt_kind == KIND_TS && idx == 3) begin
              ts_seen_q = 1'b1;
              ts_val_q = body_word;
              ts_at_q = it.arrival_time;
            end else if (!fixed_kind && opt_kind == cfg_int_kind && idx == 1) begin
              telem_q = body_word[15:0];
            end
          end
          body_left = body_left - 8'd1;
          if (body_left == 8'd0) parse_ph = PH_KIND;
          else if (parse_ph != PH_BODY_REST) parse_ph = phase_t'(parse_ph + 3'd1);
        end
      endcase
    end
    if (pos_count != 6'd63) pos_count = pos_count + 6'd1;
    if (it.last_byte) begin
      s.peer_mss = mss_q;
      s.effective_mss = eff_mss_q;
      s.peer_window_scale = wscale_q;
      s.sack_permitted = sackp_q;
      s.timestamp_seen = ts_seen_q;
      s.recent_timestamp = ts_val_q;
      s.timestamp_update_time = ts_at_q;
      s.telemetry_value = telem_q;
      expected_summaries.push_back(s);
      pos_count = '0;
      parse_ph = PH_KIND;
      opt_kind = '0;
      body_left = '0;
      body_word = '0;
      halted = 1'b0;
    end
  endtask

  task automatic compare_summary(input summary_t want, input summary_t got);
    if (got.peer_mss !== want.peer_mss) begin
      $error("peer_mss expected %0h got %0h", want.peer_mss, got.peer_mss);
      error_count++;
    end
    if (got.effective_mss !== want.effective_mss) begin
      $error("effective_mss expected %0h got %0h", want.effective_mss, got.effective_mss);
      error_count++;
    end
    if (got.peer_window_scale !== want.peer_window_scale) begin
      $error("peer_window_scale expected %0h got %0h",
             want.peer_window_scale, got.peer_window_scale);
      error_count++;
    end
    if (got.sack_permitted !== want.sack_permitted) begin
      $error("sack_permitted expected %0b got %0b", want.sack_permitted, got.sack_permitted);
      error_count++;
    end
    if (got.timestamp_seen !== want.timestamp_seen) begin
      $error("timestamp_seen expected %0b got %0b", want.timestamp_seen, got.timestamp_seen);
      error_count++;
    end
    if (got.recent_timestamp !== want.recent_timestamp) begin
      $error("recent_timestamp expected %0h got %0h",
             want.recent_timestamp, got.recent_timestamp);
      error_count++;
    end
    if (got.timestamp_update_time !== want.timestamp_update_time) begin
      $error("timestamp_update_time expected %0h got %0h",
             want.timestamp_update_time, got.timestamp_update_time);
      error_count++;
    end
    if (got.telemetry_value !== want.telemetry_value) begin
      $error("telemetry_value expected %0h got %0h", want.telemetry_value, got.telemetry_value);
      error_count++;
    end
  endtask

  // Monitor: predict on every accepted item, check every accepted summary
  always @(posedge clk) begin
    summary_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        taken_count++;
        advance_parser('{in_opt_byte, in_last_byte, in_block_length, in_arrival_time});
      end
      if (out_valid && !out_stall) begin
        got = '{out_peer_mss, out_effective_mss, out_peer_window_scale, out_sack_permitted,
                out_timestamp_seen, out_recent_timestamp, out_timestamp_update_time,
                out_telemetry_value};
        if (expected_summaries.size() == 0) begin
          $error("summary item arrived with none expected");
          error_count++;
        end else begin
          compare_summary(expected_summaries.pop_front(), got);
        end
      end
    end
  end

  // Driver: offer the next pending item once the current one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || taken_count == offered_count) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        next_item = pending_bytes.pop_front();
        in_opt_byte <= next_item.opt_byte;
        in_last_byte <= next_item.last_byte;
        in_block_length <= next_item.block_length;
        in_arrival_time <= next_item.arrival_time;
        in_valid <= 1'b1;
        offered_count++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: long hold-off when requested, random stalls otherwise
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_cycles = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_cycles != 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tcp_option_parser verification failed");
      $finish;
    end
  end

  // Write a register, read it back, and mirror it in the predictor
  task automatic set_register(input logic idx, input logic [31:0] val);
    logic [31:0] mask;
    mask = (idx == REG_MSS_OVERHEAD) ? 32'h3F : 32'hFF;
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable = 1'b0; pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) !== (val & mask)) begin
      $error("register %0d readback expected %0h got %0h", idx, val & mask, prdata & mask);
      error_count++;
    end
    @(negedge clk);
    psel = 1'b0; penable = 1'b0;
    if (idx == REG_MSS_OVERHEAD) cfg_overhead = val[5:0];
    else cfg_int_kind = val[7:0];
  endtask

  // Queue n_send items of one block; bytes past the built content are random
  task automatic queue_block(input int len_field, input logic [7:0] seg[$], input int n_send);
    opt_item_t it;
    int pick;
    for (int i = 0; i < n_send; i++) begin
      it.opt_byte = (i < seg.size()) ? seg[i] : 8'($urandom);
      it.last_byte = (i == n_send - 1);
      it.block_length = 6'(len_field);
      pick = $urandom_range(9);
      it.arrival_time = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
      pending_bytes.push_back(it);
      queued_count++;
    end
  endtask

  // Append one option, mostly well formed, sometimes odd or broken
  task automatic append_option(ref logic [7:0] seg[$]);
    int pick;
    int olen;
    logic [7:0] k;
    pick = $urandom_range(15);
    case (pick)
      0, 1: seg.push_back(KIND_NOP);
      2, 3, 4: begin
        seg.push_back(KIND_MSS); seg.push_back(8'd4);
        seg.push_back(8'($urandom)); seg.push_back(8'($urandom));
      end
      5: begin
        seg.push_back(KIND_WSCALE); seg.push_back(8'd3); seg.push_back(8'($urandom));
      end
      6: begin
        seg.push_back(KIND_SACKP); seg.push_back(8'd2);
      end
      7, 8: begin
        seg.push_back(KIND_TS); seg.push_back(8'd10);
        repeat (8) seg.push_back(8'($urandom));
      end
      9, 10: begin
        seg.push_back(cfg_int_kind); seg.push_back(8'd4);
        seg.push_back(8'($urandom)); seg.push_back(8'($urandom));
      end
      11: begin
        // known kind with an odd body length
        case ($urandom_range(4))
          0: k = KIND_MSS;
          1: k = KIND_WSCALE;
          2: k = KIND_SACKP;
          3: k = KIND_TS;
          default: k = cfg_int_kind;
        endcase
        olen = $urandom_range(12, 2);
        seg.push_back(k); seg.push_back(8'(olen));
        repeat (olen - 2) seg.push_back(8'($urandom));
      end
      12, 13: begin
        // random kind of 5 or more, which may also hit the timestamp or telemetry kind
        olen = $urandom_range(10, 2);
        seg.push_back(8'($urandom_range(255, 5))); seg.push_back(8'(olen));
        repeat (olen - 2) seg.push_back(8'($urandom));
      end
      14: seg.push_back(KIND_END);
      default: begin
        // short length byte
        seg.push_back(8'($urandom_range(255, 2))); seg.push_back(8'($urandom_range(1)));
      end
    endcase
  endtask

  task automatic queue_segment();
    logic [7:0] seg[$];
    int pick;
    int len_field;
    int n_send;
    pick = $urandom_range(99);
    if (pick < 50) len_field = $urandom_range(12, 1);
    else if (pick < 92) len_field = $urandom_range(40, 13);
    else if (pick < 97) len_field = $urandom_range(63, 41);
    else len_field = 0;
    if ($urandom_range(99) < 85) begin
      while (seg.size() < len_field) append_option(seg);
      if (seg.size() != 0 && $urandom_range(99) < 15)
        seg[$urandom_range(seg.size() - 1)] = 8'($urandom);
    end else begin
      repeat (len_field) seg.push_back(8'($urandom));
    end
    // full block, truncated by an early last byte, or with bytes past its end
    pick = $urandom_range(99);
    if (len_field == 0) n_send = $urandom_range(3, 1);
    else if (pick < 10) n_send = $urandom_range(len_field, 1);
    else if (pick < 16) n_send = len_field + $urandom_range(4, 1);
    else n_send = len_field;
    queue_block(len_field, seg, n_send);
  endtask

  task automatic queue_random(input int target);
    int start;
    start = queued_count;
    while (queued_count - start < target) queue_segment();
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_valid || expected_summaries.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [7:0] seg[$];
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed blocks under reset configuration
    seg = '{KIND_NOP, KIND_MSS, 8'd4, 8'hFF, 8'hFF, KIND_SACKP, 8'd2, KIND_END};
    queue_block(8, seg, 8);
    seg = '{KIND_TS, 8'd10, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd1, 8'd2, 8'd3, 8'd4};
    queue_block(10, seg, 10);
    seg = '{KIND_WSCALE, 8'd3, 8'hFF, INT_OPTION_KIND_RST, 8'd1};
    queue_block(5, seg, 5);
    seg = '{KIND_MSS, 8'd9};
    queue_block(2, seg, 2);
    seg = '{INT_OPTION_KIND_RST, 8'd4, 8'hAB};
    queue_block(40, seg, 3);
    wait_drained();

    // Minimum settings, no idling
    set_register(REG_MSS_OVERHEAD, 32'd0);
    set_register(REG_INT_OPTION_KIND, 32'd0);
    queue_random(190);
    wait_drained();

    // Overhead 40 and the largest telemetry kind, sender idle often
    set_register(REG_MSS_OVERHEAD, 32'd40);
    set_register(REG_INT_OPTION_KIND, 32'd255);
    sender_idle_pct = 68;
    queue_random(190);
    wait_drained();

    // Telemetry kind aliasing MSS; receiver stalls, with one long hold-off
    set_register(REG_MSS_OVERHEAD, 32'($urandom_range(40)));
    set_register(REG_INT_OPTION_KIND, 32'(KIND_MSS));
    sender_idle_pct = 0;
    recv_stall_pct = 68;
    hold_requests++;
    queue_random(190);
    wait_drained();

    // Both sides idle; sender pauses until drained between halves
    set_register(REG_MSS_OVERHEAD, 32'($urandom_range(40)));
    set_register(REG_INT_OPTION_KIND, 32'(KIND_NOP));
    sender_idle_pct = 34;
    recv_stall_pct = 34;
    queue_random(95);
    wait_drained();
    set_register(REG_MSS_OVERHEAD, 32'($urandom_range(40)));
    set_register(REG_INT_OPTION_KIND, 32'($urandom_range(255)));
    queue_random(95);
    wait_drained();

    if (error_count == 0) begin
      $display("tcp_option_parser verification clean");
    end else begin
      $display("tcp_option_parser verification failed");
    end
    $finish;
  end

endmodule
